// ===== rtl/mom_pkg.sv =====
// Package for the median-of-means pixel merge: sizes, payload and control types.
// Used by every module in rtl except mom_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mom_pkg;
    localparam int PixelChannels = 1024;
    localparam int MaxMeans      = 16;
    localparam int IdxW          = $clog2(PixelChannels);
    localparam int PosW          = $clog2(MaxMeans);
    localparam int CntW          = $clog2(MaxMeans + 1);
    localparam int SumW          = 40;
    localparam int ValW          = 32;
    localparam int GrpW          = 9;
    localparam int ImgW          = 8;
    localparam int GnW           = 5;
    localparam logic [GrpW-1:0] GroupReset = GrpW'(10);
    localparam logic [SumW-1:0] SumMax     = {SumW{1'b1}};
    localparam int QueueDepth    = 4;
    localparam int QPtrW         = $clog2(QueueDepth);

    typedef struct packed {
        logic [IdxW-1:0] pixel_index;
        logic [ValW-1:0] sample_value;
        logic            last_of_image;
    } t_in_item;

    typedef struct packed {
        logic [IdxW-1:0] out_pixel_index;
        logic [ValW-1:0] median_value;
        logic [GnW-1:0]  group_number;
        logic            overflow;
    } t_out_item;

    // Work passed from the front part to the back part.
    typedef struct packed {
        logic [IdxW-1:0] pixel_index;
        logic [SumW-1:0] sum;
        logic [GrpW-1:0] divisor;
        logic [CntW-1:0] count;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE, F_READ, F_WRITE
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE, B_DIV, B_SCAN_RD, B_SCAN, B_SHIFT_RD, B_SHIFT, B_PUT,
        B_MED_RD, B_MED_A, B_MED_B, B_OUT
    } t_back_state;
endpackage
`default_nettype wire

// ===== rtl/mom_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none
module mom_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/mom_front.sv =====
// Front part: accumulates channel sums, tracks image phase, issues closing jobs.
// Depends on mom_pkg and mom_ram.
`timescale 1ns / 1ps
`default_nettype none
module mom_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire mom_pkg::t_in_item          i_item,
    output logic                            o_full,
    input  wire logic [mom_pkg::GrpW-1:0]   i_group_size,
    output logic                            o_job_valid,
    output mom_pkg::t_job                   o_job,
    input  wire logic                       i_job_ready,
    output logic                            o_busy
);
    mom_pkg::t_front_state r_state, n_state;
    logic                          r_clr_done, n_clr_done;
    logic [mom_pkg::IdxW:0]        r_clr_cnt, n_clr_cnt;
    mom_pkg::t_in_item             r_item;
    logic                          r_closing;
    logic [mom_pkg::GrpW-1:0]      r_div;
    logic [mom_pkg::CntW-1:0]      r_count;
    logic [mom_pkg::ImgW-1:0]      r_imgs, n_imgs;
    logic [mom_pkg::GnW-1:0]       r_groups, n_groups;
    logic [mom_pkg::SumW-1:0]      w_rdata, w_sum, w_wdata;
    logic [mom_pkg::SumW:0]        w_add;
    logic                          w_we;
    logic [mom_pkg::IdxW-1:0]      w_waddr;
    logic [mom_pkg::IdxW-1:0]      w_raddr;
    logic [mom_pkg::GrpW-1:0]      w_eff;
    logic                          w_closing;
    logic                          w_accept;

    // Read the incoming channel while idle, hold the address while an item is in work
    assign w_raddr = (r_state == mom_pkg::F_IDLE) ? i_item.pixel_index : r_item.pixel_index;

    mom_ram #(.Width(mom_pkg::SumW), .Depth(mom_pkg::PixelChannels)) u_sums (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Clamp group size into 1..256
    always_comb begin
        if (i_group_size == '0) begin
            w_eff = mom_pkg::GrpW'(1);
        end else if (i_group_size > mom_pkg::GrpW'(256)) begin
            w_eff = mom_pkg::GrpW'(256);
        end else begin
            w_eff = i_group_size;
        end
        w_closing = ({1'b0, r_imgs} + 9'd1) >= w_eff;
    end

    assign o_full   = !r_clr_done || r_state != mom_pkg::F_IDLE;
    assign w_accept = i_push && !o_full;
    assign o_busy   = r_state != mom_pkg::F_IDLE;

    // Saturating add of sample into sum
    assign w_add = {1'b0, w_rdata} + {9'd0, r_item.sample_value};
    assign w_sum = w_add[mom_pkg::SumW] ? mom_pkg::SumMax : w_add[mom_pkg::SumW-1:0];

    always_comb begin
        o_job.pixel_index = r_item.pixel_index;
        o_job.sum         = w_sum;
        o_job.divisor     = r_div;
        o_job.count       = r_count;
        o_job_valid       = r_state == mom_pkg::F_READ && r_closing;
    end

    // Sequencer: clear sweep, accept, read-modify-write
    always_comb begin
        n_state    = r_state;
        n_clr_done = r_clr_done;
        n_clr_cnt  = r_clr_cnt;
        n_imgs     = r_imgs;
        n_groups   = r_groups;
        w_we       = 1'b0;
        w_waddr    = r_item.pixel_index;
        w_wdata    = w_sum;
        if (!r_clr_done) begin
            w_we      = 1'b1;
            w_waddr   = r_clr_cnt[mom_pkg::IdxW-1:0];
            w_wdata   = '0;
            n_clr_cnt = r_clr_cnt + 1'b1;
            if (r_clr_cnt == (mom_pkg::IdxW+1)'(mom_pkg::PixelChannels - 1)) begin
                n_clr_done = 1'b1;
            end
        end
        unique case (r_state)
            mom_pkg::F_IDLE: begin
                if (w_accept) begin
                    n_state = mom_pkg::F_READ;
                    if (i_item.last_of_image) begin
                        if (w_closing) begin
                            n_imgs = '0;
                            if (r_groups < mom_pkg::GnW'(mom_pkg::MaxMeans)) begin
                                n_groups = r_groups + 1'b1;
                            end
                        end else begin
                            n_imgs = r_imgs + 1'b1;
                        end
                    end
                end
            end
            mom_pkg::F_READ: begin
                if (!r_closing || i_job_ready) begin
                    w_we    = 1'b1;
                    w_wdata = r_closing ? '0 : w_sum;
                    n_state = mom_pkg::F_WRITE;
                end
            end
            mom_pkg::F_WRITE: begin
                n_state = mom_pkg::F_IDLE;
            end
            default: n_state = mom_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mom_pkg::F_IDLE;
            r_clr_done <= 1'b0;
            r_clr_cnt  <= '0;
            r_imgs     <= '0;
            r_groups   <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_done <= n_clr_done;
            r_clr_cnt  <= n_clr_cnt;
            r_imgs     <= n_imgs;
            r_groups   <= n_groups;
        end
    end

    // Hold the accepted item and its classification
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item    <= i_item;
            r_closing <= w_closing;
            r_div     <= w_eff;
            r_count   <= (r_groups < mom_pkg::GnW'(mom_pkg::MaxMeans))
                         ? mom_pkg::CntW'(r_groups) : mom_pkg::CntW'(mom_pkg::MaxMeans);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mom_queue.sv =====
// Short job queue between the front and back parts.
// Depends on mom_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mom_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire mom_pkg::t_job i_job,
    output logic               o_ready,
    output logic               o_valid,
    output mom_pkg::t_job      o_job,
    input  wire logic          i_ready
);
    mom_pkg::t_job                r_buf [mom_pkg::QueueDepth];
    logic [mom_pkg::QPtrW-1:0]    r_wp, r_rp;
    logic [mom_pkg::QPtrW:0]      r_cnt;
    logic                         w_wr, w_rd;

    assign o_ready = r_cnt != (mom_pkg::QPtrW+1)'(mom_pkg::QueueDepth);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_buf[r_rp];
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (mom_pkg::QPtrW+1)'(w_wr) - (mom_pkg::QPtrW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_buf[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

// ===== rtl/mom_back.sv =====
// Back part: divides sum, inserts mean into sorted list unless full, forms median.
// Depends on mom_pkg and mom_ram.
`timescale 1ns / 1ps
`default_nettype none
module mom_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire mom_pkg::t_job i_job,
    output logic               o_ready,
    output logic               o_valid,
    output mom_pkg::t_out_item o_item,
    input  wire logic          i_ready,
    output logic               o_busy
);
    mom_pkg::t_back_state          r_state, n_state;
    mom_pkg::t_job                 r_job;
    logic [mom_pkg::SumW-1:0]      r_quo;
    logic [mom_pkg::GrpW-1:0]      r_rem;
    logic [5:0]                    r_bit;
    logic [mom_pkg::ValW-1:0]      r_mean;
    logic [mom_pkg::CntW-1:0]      r_pos;
    logic [mom_pkg::CntW-1:0]      r_i;
    logic [mom_pkg::ValW-1:0]      r_a;
    logic [mom_pkg::ValW:0]        w_avg;
    mom_pkg::t_out_item            r_out;
    logic                          w_we;
    logic [mom_pkg::PosW-1:0]      w_wpos, w_rpos;
    logic [mom_pkg::ValW-1:0]      w_wdata, w_rdata;
    logic [mom_pkg::GrpW:0]        w_trial;
    logic                          w_even;
    logic [mom_pkg::CntW-1:0]      w_n, w_half;

    mom_ram #(.Width(mom_pkg::ValW), .Depth(mom_pkg::PixelChannels * mom_pkg::MaxMeans)) u_list (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr({r_job.pixel_index, w_wpos}),
        .i_wdata(w_wdata),
        .i_raddr({r_job.pixel_index, w_rpos}),
        .o_rdata(w_rdata)
    );

    assign o_ready = r_state == mom_pkg::B_IDLE;
    assign o_valid = r_state == mom_pkg::B_OUT;
    assign o_item  = r_out;
    assign o_busy  = r_state != mom_pkg::B_IDLE;

    // Restoring divider step: one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[mom_pkg::SumW-1]} - {1'b0, r_job.divisor};
    assign w_n     = (r_job.count == mom_pkg::CntW'(mom_pkg::MaxMeans))
                     ? r_job.count : r_job.count + 1'b1;
    assign w_even  = !w_n[0];
    assign w_half  = w_n >> 1;
    assign w_avg   = ({1'b0, r_a} + {1'b0, w_rdata}) >> 1;

    // Sequencer
    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_wpos  = r_i[mom_pkg::PosW-1:0];
        w_wdata = r_mean;
        w_rpos  = r_i[mom_pkg::PosW-1:0];
        unique case (r_state)
            mom_pkg::B_IDLE:     if (i_valid) n_state = mom_pkg::B_DIV;
            mom_pkg::B_DIV:      if (r_bit == 6'd0) n_state = mom_pkg::B_SCAN_RD;
            mom_pkg::B_SCAN_RD: begin
                if (r_job.count == mom_pkg::CntW'(mom_pkg::MaxMeans)) begin
                    n_state = mom_pkg::B_MED_RD;
                end else if (r_i == r_job.count) begin
                    n_state = mom_pkg::B_SHIFT_RD;
                end else begin
                    n_state = mom_pkg::B_SCAN;
                end
            end
            // stop the search at the first entry not below the mean
            mom_pkg::B_SCAN:     n_state = (r_mean > w_rdata) ? mom_pkg::B_SCAN_RD
                                                              : mom_pkg::B_SHIFT_RD;
            mom_pkg::B_SHIFT_RD: begin
                // read entry i-1 for a shift up into i
                w_rpos = r_i[mom_pkg::PosW-1:0] - 1'b1;
                n_state = (r_i == r_pos) ? mom_pkg::B_PUT : mom_pkg::B_SHIFT;
            end
            mom_pkg::B_SHIFT: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_state = mom_pkg::B_SHIFT_RD;
            end
            mom_pkg::B_PUT: begin
                w_we    = 1'b1;
                w_wpos  = r_pos[mom_pkg::PosW-1:0];
                n_state = mom_pkg::B_MED_RD;
            end
            mom_pkg::B_MED_RD: begin
                w_rpos  = w_even ? w_half[mom_pkg::PosW-1:0] - 1'b1 : w_half[mom_pkg::PosW-1:0];
                n_state = mom_pkg::B_MED_A;
            end
            mom_pkg::B_MED_A: begin
                w_rpos  = w_half[mom_pkg::PosW-1:0];
                n_state = w_even ? mom_pkg::B_MED_B : mom_pkg::B_OUT;
            end
            mom_pkg::B_MED_B:    n_state = mom_pkg::B_OUT;
            mom_pkg::B_OUT:      if (i_ready) n_state = mom_pkg::B_IDLE;
            default:             n_state = mom_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mom_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mom_pkg::B_IDLE: begin
                r_job <= i_job;
                r_quo <= i_job.sum;
                r_rem <= '0;
                r_bit <= 6'(mom_pkg::SumW - 1);
                r_i   <= '0;
            end
            mom_pkg::B_DIV: begin
                r_quo <= {r_quo[mom_pkg::SumW-2:0], !w_trial[mom_pkg::GrpW]};
                r_rem <= w_trial[mom_pkg::GrpW] ? {r_rem[mom_pkg::GrpW-2:0], r_quo[mom_pkg::SumW-1]}
                                                : w_trial[mom_pkg::GrpW-1:0];
                r_bit <= r_bit - 1'b1;
                if (r_bit == 6'd0) begin
                    r_mean <= r_quo[mom_pkg::SumW-2:mom_pkg::ValW-1] != '0 ? '1
                              : {r_quo[mom_pkg::ValW-2:0], !w_trial[mom_pkg::GrpW]};
                end
            end
            mom_pkg::B_SCAN_RD: begin
                if (r_i == r_job.count) begin
                    r_pos <= r_i;
                end
            end
            mom_pkg::B_SCAN: begin
                if (r_mean > w_rdata) begin
                    r_i <= r_i + 1'b1;
                end else begin
                    r_pos <= r_i;
                    r_i   <= r_job.count;
                end
            end
            mom_pkg::B_SHIFT: r_i <= r_i - 1'b1;
            mom_pkg::B_MED_B: r_a <= w_rdata;
            mom_pkg::B_OUT: ;
            default: ;
        endcase
        if (r_state == mom_pkg::B_MED_A) begin
            r_a <= w_rdata;
            r_out.out_pixel_index <= r_job.pixel_index;
            r_out.median_value    <= w_rdata;
            r_out.group_number    <= mom_pkg::GnW'(w_n);
            r_out.overflow        <= r_job.count == mom_pkg::CntW'(mom_pkg::MaxMeans);
        end
        if (r_state == mom_pkg::B_MED_B) begin
            r_out.median_value <= w_avg[mom_pkg::ValW-1:0];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/median_of_means_pixel_merge.sv =====
// Top level of the median-of-means pixel merge: front, job queue, back.
// Depends on mom_pkg, mom_front, mom_queue, mom_back.
//
// Usage:
//   Input queue: drive i_item and raise i_push; the item is taken at an edge
//   with o_full low. Result queue: while o_empty is low, o_item holds the
//   oldest result; raise i_pop to take it.
//   Configuration: i_cfg_valid / o_cfg_ready carry group_size; write only
//   while the block is idle.
//   Each item goes through the front states idle, read and write (sum memory
//   read, modify, write); a group-closing item waits in read until the job
//   queue takes its job. Items of a group-closing image then go through the
//   back part: it takes the job, runs the one-bit-per-cycle divider, searches
//   and shifts the list entry by entry, places the mean unless the list is
//   full, and forms the median and output; it takes no new job until its
//   result is popped, and a 4-entry job queue lets the front run ahead.
//   After reset the front sweeps all 1024 entries of the sum memory to zero
//   with o_full high. A stalled result holds the back part; the queue fills
//   and then o_full rises.
`timescale 1ns / 1ps
`default_nettype none
module median_of_means_pixel_merge (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire mom_pkg::t_in_item        i_item,
    output logic                          o_full,
    output logic                          o_empty,
    input  wire logic                     i_pop,
    output mom_pkg::t_out_item            o_item,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [mom_pkg::GrpW-1:0] i_cfg_data
);
    logic [mom_pkg::GrpW-1:0] r_group_size;
    logic                     w_fj_valid, w_fj_ready, w_bj_valid, w_bj_ready;
    mom_pkg::t_job            w_fj, w_bj;
    logic                     w_out_valid, w_fbusy, w_bbusy;

    assign o_cfg_ready = 1'b1;

    // Hold the group size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= mom_pkg::GroupReset;
        end else if (i_cfg_valid) begin
            r_group_size <= i_cfg_data;
        end
    end

    mom_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_group_size(r_group_size),
        .o_job_valid (w_fj_valid),
        .o_job       (w_fj),
        .i_job_ready (w_fj_ready),
        .o_busy      (w_fbusy)
    );

    mom_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_fj_valid),
        .i_job  (w_fj),
        .o_ready(w_fj_ready),
        .o_valid(w_bj_valid),
        .o_job  (w_bj),
        .i_ready(w_bj_ready)
    );

    mom_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_bj_valid),
        .i_job  (w_bj),
        .o_ready(w_bj_ready),
        .o_valid(w_out_valid),
        .o_item (o_item),
        .i_ready(i_pop),
        .o_busy (w_bbusy)
    );

    assign o_empty = !w_out_valid;

    // A result never appears without the back part being busy
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> w_bbusy) else $error("result without back activity");
    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_item)))
        else $error("result changed while stalled");
    // Front takes no item while it works on one
    a_front_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fbusy |-> o_full) else $error("input open while front busy");
    // Group number never exceeds the list depth
    a_gn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_item.group_number <= mom_pkg::GnW'(mom_pkg::MaxMeans)
                      && o_item.group_number != '0))
        else $error("group number out of range");
endmodule
`default_nettype wire
